>>> hdl/pmss_pkg.sv
// Package for the PID motor speed-sync controller: item types, register
// codes and fixed constants shared by the RTL and the checker.
// Depends on nothing.
package pmss_pkg;

  localparam int COUNT_W   = 31;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd512;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;

  // One million microseconds per second.
  localparam int                 MICRO_W = 20;
  localparam logic [MICRO_W-1:0] MICRO   = 20'd1000000;

  // Running sum limits and the clamp on the derivative term.
  localparam int                SUM_W   = 64;
  localparam logic [SUM_W-1:0]  SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]  SUM_MIN = 64'h8000_0000_0000_0001;
  localparam int                TERM_W  = 61;
  localparam logic [TERM_W-1:0] TERM_LIMIT = 61'h1000_0000_0000_0000;

  // Bits of the integral quotient that can be nonzero.
  localparam int IQ_W = 60;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd255;

  typedef struct packed {
    logic [COUNT_W-1:0] target_count;
    logic [COUNT_W-1:0] measured_count;
    logic [TIME_W-1:0]  elapsed_us;
  } pmss_in_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_level;
    logic               saturated;
    logic               stopped;
  } pmss_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pmss_div_stat_t;

endpackage

>>> hdl/pmss_serial_div.sv
// Bit-serial restoring divider for the PID speed-sync controller.
// One quotient bit per cycle; uses pmss_pkg for its status type.
module pmss_serial_div #(
  parameter int N_W = 52,
  parameter int D_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [N_W-1:0]          dividend,
  input  logic [D_W-1:0]          divisor,
  output logic [N_W-1:0]          quotient,
  output pmss_pkg::pmss_div_stat_t stat
);

  localparam int              CNT_W = $clog2(N_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(N_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   den_r, den_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;

  logic [D_W:0] trial;
  logic [D_W:0] reduced;
  logic         ge;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  assign trial   = {rem_r, quo_r[N_W-1]};
  assign reduced = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? reduced[D_W-1:0] : trial[D_W-1:0];
      quo_nxt = {quo_r[N_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/pid_motor_speed_sync.sv
// Top level of the PID motor speed-sync controller: sequencer, bit-serial
// multipliers, running-sum state and output register.
// Depends on pmss_pkg and pmss_serial_div.
//
//   Channel  | Ports                                   | Transfer rule
//   ---------+-----------------------------------------+----------------------------
//   input    | in_valid, in_stall, in_data             | in_valid high, in_stall low
//   result   | out_valid, out_stall, out_data          | out_valid high, out_stall low
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready high
//
// An item is accepted only while idle; no new item is taken until the result of
// the last one is loaded, after the 32-step error times time multiply, two
// 16-step gain multiplies and the 79-step integral divide by one million.
// Reset (rst_n low at a clock edge) restores the gains, clears the previous
// error, the running sum and any pending result. A stalled result waits in
// the output register while the next item is processed.
module pid_motor_speed_sync (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pmss_pkg::pmss_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pmss_pkg::pmss_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmss_pkg::GAIN_W-1:0]       cfg_data
);

  // Widths of the datapath, all following from the fixed field widths.
  localparam int CW     = pmss_pkg::COUNT_W;
  localparam int TW     = pmss_pkg::TIME_W;
  localparam int GW     = pmss_pkg::GAIN_W;
  localparam int MW     = pmss_pkg::MICRO_W;
  localparam int SW     = pmss_pkg::SUM_W;
  localparam int ED_W   = CW + TW;      // |error| * dt
  localparam int DN_W   = TW + MW;      // |error delta| * 1e6
  localparam int P_W    = CW + GW;      // kp * |error|
  localparam int SMAG_W = SW - 1;       // |running sum|
  localparam int I_W    = SMAG_W + GW;  // ki * |running sum|
  localparam int MD_W   = DN_W + GW;    // kd * |derivative|
  localparam int CNT_W  = $clog2(TW);

  localparam logic [CNT_W-1:0] MUL1_LAST = CNT_W'(TW - 1);
  localparam logic [CNT_W-1:0] GAIN_LAST = CNT_W'(GW - 1);

  // Sequencer states.
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_PREP_E = 4'd1;
  localparam logic [ST_W-1:0] ST_PREP_D = 4'd2;
  localparam logic [ST_W-1:0] ST_MUL1   = 4'd3;
  localparam logic [ST_W-1:0] ST_SUM1   = 4'd4;
  localparam logic [ST_W-1:0] ST_SUM2   = 4'd5;
  localparam logic [ST_W-1:0] ST_SUM3   = 4'd6;
  localparam logic [ST_W-1:0] ST_MUL2   = 4'd7;
  localparam logic [ST_W-1:0] ST_DIVGO  = 4'd8;
  localparam logic [ST_W-1:0] ST_DIV    = 4'd9;
  localparam logic [ST_W-1:0] ST_MUL3   = 4'd10;
  localparam logic [ST_W-1:0] ST_FIN1   = 4'd11;
  localparam logic [ST_W-1:0] ST_FIN2   = 4'd12;
  localparam logic [ST_W-1:0] ST_FIN3   = 4'd13;
  localparam logic [ST_W-1:0] ST_OUT    = 4'd14;

  // Control state.
  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [GW-1:0]    prop_gain_r, prop_gain_nxt;
  logic [GW-1:0]    deriv_gain_r, deriv_gain_nxt;
  logic [GW-1:0]    integ_gain_r, integ_gain_nxt;
  logic [TW-1:0]    last_error_r, last_error_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;

  // Datapath registers.
  pmss_pkg::pmss_in_t  in_r, in_nxt;
  pmss_pkg::pmss_out_t out_r, out_nxt;
  logic [TW-1:0]     err_r, err_nxt;
  logic [CW-1:0]     err_mag_r, err_mag_nxt;
  logic              err_neg_r, err_neg_nxt;
  logic              stop_r, stop_nxt;
  logic              dt_zero_r, dt_zero_nxt;
  logic [TW-1:0]     diff_mag_r, diff_mag_nxt;
  logic              diff_neg_r, diff_neg_nxt;
  logic [ED_W-1:0]   m_ed_r, m_ed_nxt;
  logic [DN_W-1:0]   m_dn_r, m_dn_nxt;
  logic [P_W-1:0]    m_p_r, m_p_nxt;
  logic [I_W-1:0]    m_i_r, m_i_nxt;
  logic [MD_W-1:0]   m_d_r, m_d_nxt;
  logic [SW-1:0]     prod_r, prod_nxt;
  logic [SMAG_W-1:0] sum_mag_r, sum_mag_nxt;
  logic              sum_neg_r, sum_neg_nxt;
  logic [SW-1:0]     pterm_r, pterm_nxt;
  logic [SW-1:0]     dterm_r, dterm_nxt;
  logic [SW-1:0]     iterm_r, iterm_nxt;
  logic [SW-1:0]     part_r, part_nxt;
  logic [SW-1:0]     total_r, total_nxt;

  // Shift-and-add steps of the serial multipliers: the low end of each
  // product register holds the multiplier bits not yet used.
  logic [CW:0]     ed_add;
  logic [TW:0]     dn_add;
  logic [CW:0]     p_add;
  logic [SMAG_W:0] i_add;
  logic [DN_W:0]   d_add;
  logic [DN_W-1:0] der_a;

  // Other combinational terms.
  logic            meas_ge;
  logic [TW:0]     diff_fw;
  logic [TW:0]     diff_bw;
  logic [SW:0]     sum_wide;
  logic            sum_pos_ovf;
  logic            sum_neg_ovf;
  logic [pmss_pkg::TERM_W-1:0] d_lim;
  logic [SW-1:0]   tot_mag;
  logic            clamp;
  logic            out_load;

  // Divider interfaces.
  logic                     der_start;
  logic                     int_start;
  logic [DN_W-1:0]          der_quo;
  logic [I_W-1:0]           int_quo;
  pmss_pkg::pmss_div_stat_t der_stat;
  pmss_pkg::pmss_div_stat_t int_stat;

  // The derivative quotient; it counts as zero when no time has elapsed.
  assign der_a = dt_zero_r ? '0 : der_quo;

  assign ed_add = {1'b0, m_ed_r[ED_W-1:TW]}  + (m_ed_r[0] ? {1'b0, err_mag_r}  : '0);
  assign dn_add = {1'b0, m_dn_r[DN_W-1:MW]}  + (m_dn_r[0] ? {1'b0, diff_mag_r} : '0);
  assign p_add  = {1'b0, m_p_r[P_W-1:GW]}    + (m_p_r[0]  ? {1'b0, err_mag_r}  : '0);
  assign i_add  = {1'b0, m_i_r[I_W-1:GW]}    + (m_i_r[0]  ? {1'b0, sum_mag_r}  : '0);
  assign d_add  = {1'b0, m_d_r[MD_W-1:GW]}   + (m_d_r[0]  ? {1'b0, der_a}      : '0);

  // The error delta is formed both ways so that its magnitude needs no
  // negation after the subtraction.
  assign meas_ge = in_r.measured_count >= in_r.target_count;
  assign diff_fw = {err_r[TW-1], err_r} - {last_error_r[TW-1], last_error_r};
  assign diff_bw = {last_error_r[TW-1], last_error_r} - {err_r[TW-1], err_r};

  // Running sum with saturation at plus or minus (2^63 - 1). Minus 2^63
  // itself also saturates.
  assign sum_wide    = {sum_r[SW-1], sum_r} + {prod_r[SW-1], prod_r};
  assign sum_pos_ovf = !sum_wide[SW] && sum_wide[SW-1];
  assign sum_neg_ovf = sum_wide[SW] && (!sum_wide[SW-1] || (sum_wide[SW-2:0] == '0));

  assign d_lim = (m_d_r > MD_W'(pmss_pkg::TERM_LIMIT)) ? pmss_pkg::TERM_LIMIT
                                                       : m_d_r[pmss_pkg::TERM_W-1:0];

  // Magnitude of the control value, truncated to whole Q.8 units; any bit
  // above the low byte of the integer part means a clamp.
  assign tot_mag = total_r[SW-1] ? (SW'(0) - total_r) : total_r;
  assign clamp   = |tot_mag[SW-1:16];

  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign der_start = (state_r == ST_SUM3) && !dt_zero_r;
  assign int_start = (state_r == ST_DIVGO);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Derivative: |delta| * 1e6 / dt.
  pmss_serial_div #(
    .N_W(DN_W),
    .D_W(TW)
  ) u_der_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (der_start),
    .dividend (m_dn_r),
    .divisor  (in_r.elapsed_us),
    .quotient (der_quo),
    .stat     (der_stat)
  );

  // Integral term: ki * |sum| / 1e6, one quotient bit per cycle.
  pmss_serial_div #(
    .N_W(I_W),
    .D_W(MW)
  ) u_int_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (int_start),
    .dividend (m_i_r),
    .divisor  (pmss_pkg::MICRO),
    .quotient (int_quo),
    .stat     (int_stat)
  );

  // Configuration writes; an index past the last register is ignored.
  always_comb begin
    prop_gain_nxt  = prop_gain_r;
    deriv_gain_nxt = deriv_gain_r;
    integ_gain_nxt = integ_gain_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmss_pkg::CFG_PROP_GAIN:  prop_gain_nxt  = cfg_data;
        pmss_pkg::CFG_DERIV_GAIN: deriv_gain_nxt = cfg_data;
        pmss_pkg::CFG_INTEG_GAIN: integ_gain_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    last_error_nxt = last_error_r;
    sum_nxt        = sum_r;
    in_nxt         = in_r;
    out_nxt        = out_r;
    err_nxt        = err_r;
    err_mag_nxt    = err_mag_r;
    err_neg_nxt    = err_neg_r;
    stop_nxt       = stop_r;
    dt_zero_nxt    = dt_zero_r;
    diff_mag_nxt   = diff_mag_r;
    diff_neg_nxt   = diff_neg_r;
    m_ed_nxt       = m_ed_r;
    m_dn_nxt       = m_dn_r;
    m_p_nxt        = m_p_r;
    m_i_nxt        = m_i_r;
    m_d_nxt        = m_d_r;
    prod_nxt       = prod_r;
    sum_mag_nxt    = sum_mag_r;
    sum_neg_nxt    = sum_neg_r;
    pterm_nxt      = pterm_r;
    dterm_nxt      = dterm_r;
    iterm_nxt      = iterm_r;
    part_nxt       = part_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = ST_PREP_E;
        end
      end
      ST_PREP_E: begin
        err_nxt     = {1'b0, in_r.measured_count} - {1'b0, in_r.target_count};
        err_mag_nxt = meas_ge ? (in_r.measured_count - in_r.target_count)
                              : (in_r.target_count - in_r.measured_count);
        err_neg_nxt = !meas_ge;
        stop_nxt    = meas_ge && (in_r.measured_count != in_r.target_count);
        dt_zero_nxt = (in_r.elapsed_us == '0);
        state_nxt   = ST_PREP_D;
      end
      ST_PREP_D: begin
        diff_neg_nxt = diff_fw[TW];
        diff_mag_nxt = diff_fw[TW] ? diff_bw[TW-1:0] : diff_fw[TW-1:0];
        m_ed_nxt     = {{CW{1'b0}}, in_r.elapsed_us};
        m_dn_nxt     = {{TW{1'b0}}, pmss_pkg::MICRO};
        m_p_nxt      = {{CW{1'b0}}, prop_gain_r};
        cnt_nxt      = '0;
        state_nxt    = ST_MUL1;
      end
      ST_MUL1: begin
        // Three products at once; the shorter multipliers stop early.
        m_ed_nxt = {ed_add, m_ed_r[TW-1:1]};
        if (cnt_r < CNT_W'(MW)) begin
          m_dn_nxt = {dn_add, m_dn_r[MW-1:1]};
        end
        if (cnt_r < CNT_W'(GW)) begin
          m_p_nxt = {p_add, m_p_r[GW-1:1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL1_LAST) begin
          state_nxt = ST_SUM1;
        end
      end
      ST_SUM1: begin
        prod_nxt  = err_neg_r ? (SW'(0) - SW'(m_ed_r)) : SW'(m_ed_r);
        state_nxt = ST_SUM2;
      end
      ST_SUM2: begin
        if (sum_pos_ovf) begin
          sum_nxt = pmss_pkg::SUM_MAX;
        end else if (sum_neg_ovf) begin
          sum_nxt = pmss_pkg::SUM_MIN;
        end else begin
          sum_nxt = sum_wide[SW-1:0];
        end
        last_error_nxt = err_r;
        state_nxt      = ST_SUM3;
      end
      ST_SUM3: begin
        // The derivative divide starts here, unless no time has elapsed, and runs alongside the integral path.
        sum_neg_nxt = sum_r[SW-1];
        sum_mag_nxt = sum_r[SW-1] ? SMAG_W'(SW'(0) - sum_r) : sum_r[SMAG_W-1:0];
        m_i_nxt     = {{SMAG_W{1'b0}}, integ_gain_r};
        cnt_nxt     = '0;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        m_i_nxt = {i_add, m_i_r[GW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == GAIN_LAST) begin
          state_nxt = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // The derivative divide is shorter and started earlier, so it is
        // finished by the time the integral divide reports done.
        if (int_stat.done && !der_stat.busy) begin
          m_d_nxt   = {{DN_W{1'b0}}, deriv_gain_r};
          cnt_nxt   = '0;
          state_nxt = ST_MUL3;
        end
      end
      ST_MUL3: begin
        m_d_nxt = {d_add, m_d_r[GW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == GAIN_LAST) begin
          state_nxt = ST_FIN1;
        end
      end
      ST_FIN1: begin
        pterm_nxt = err_neg_r ? (SW'(0) - SW'(m_p_r)) : SW'(m_p_r);
        dterm_nxt = diff_neg_r ? (SW'(0) - SW'(d_lim)) : SW'(d_lim);
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        part_nxt  = pterm_r + dterm_r;
        iterm_nxt = sum_neg_r ? (SW'(0) - SW'(int_quo[pmss_pkg::IQ_W-1:0]))
                              : SW'(int_quo[pmss_pkg::IQ_W-1:0]);
        state_nxt = ST_FIN3;
      end
      ST_FIN3: begin
        total_nxt = part_r + iterm_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_nxt.saturated   = clamp;
          out_nxt.stopped     = stop_r;
          out_nxt.drive_level = stop_r ? '0 : (clamp ? pmss_pkg::DRIVE_MAX : tot_mag[15:8]);
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      prop_gain_r  <= pmss_pkg::PROP_GAIN_RST;
      deriv_gain_r <= pmss_pkg::DERIV_GAIN_RST;
      integ_gain_r <= pmss_pkg::INTEG_GAIN_RST;
      last_error_r <= '0;
      sum_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      prop_gain_r  <= prop_gain_nxt;
      deriv_gain_r <= deriv_gain_nxt;
      integ_gain_r <= integ_gain_nxt;
      last_error_r <= last_error_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    out_r      <= out_nxt;
    err_r      <= err_nxt;
    err_mag_r  <= err_mag_nxt;
    err_neg_r  <= err_neg_nxt;
    stop_r     <= stop_nxt;
    dt_zero_r  <= dt_zero_nxt;
    diff_mag_r <= diff_mag_nxt;
    diff_neg_r <= diff_neg_nxt;
    m_ed_r     <= m_ed_nxt;
    m_dn_r     <= m_dn_nxt;
    m_p_r      <= m_p_nxt;
    m_i_r      <= m_i_nxt;
    m_d_r      <= m_d_nxt;
    prod_r     <= prod_nxt;
    sum_mag_r  <= sum_mag_nxt;
    sum_neg_r  <= sum_neg_nxt;
    pterm_r    <= pterm_nxt;
    dterm_r    <= dterm_nxt;
    iterm_r    <= iterm_nxt;
    part_r     <= part_nxt;
    total_r    <= total_nxt;
  end

endmodule

>>> hdl/pmss_checker.sv
// Port-level checker for the PID motor speed-sync controller, bound to the
// top level below. Depends on pmss_pkg.
module pmss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pmss_pkg::pmss_out_t out_data
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  // The stop rule forces zero drive.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stopped |-> out_data.drive_level == '0)
    else $error("stopped result with nonzero drive");

  // A clamped result that is not stopped drives at full scale.
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated && !out_data.stopped
      |-> out_data.drive_level == pmss_pkg::DRIVE_MAX)
    else $error("saturated result below full scale");

endmodule

bind pid_motor_speed_sync pmss_checker u_pmss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
